/* hw/rtl/ttslfp_pkg.sv */
// ----------------------------------------------------------------------------
// ttslfp_pkg
// Shared constants and types of the two-type sync/length frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttslfp_pkg;

  localparam int MAX_FRAME   = 32;
  localparam int FRAME_SLOTS = 8;

  localparam int ADDR_W  = $clog2(MAX_FRAME);
  localparam int COUNT_W = $clog2(MAX_FRAME + 1);
  localparam int SLOT_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int LEN_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 6;
  localparam int CFG_A_W = 3;

  localparam logic [CFG_A_W-1:0] REG_SYNC_FIRST  = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_SYNC_SECOND = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_TYPE_A_CODE = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_TYPE_B_CODE = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_TYPE_A_POS  = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_TYPE_B_POS  = 3'd5;
  localparam logic [CFG_A_W-1:0] REG_TYPE_A_OFS  = 3'd6;
  localparam logic [CFG_A_W-1:0] REG_TYPE_B_OFS  = 3'd7;

  typedef struct packed {
    logic               start;
    logic [COUNT_W-1:0] n;
    logic               type_b;
    logic [SLOT_W-1:0]  slot;
  } frame_done_t;

endpackage

`default_nettype wire

/* hw/rtl/ttslfp_ram.sv */
// ----------------------------------------------------------------------------
// ttslfp_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ttslfp_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [$clog2(DEPTH)-1:0]  waddr,
  input  wire logic [DATA_W-1:0]         wdata,
  input  wire logic                      re,
  input  wire logic [$clog2(DEPTH)-1:0]  raddr,
  output logic      [DATA_W-1:0]         rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ttslfp_hunt.sv */
// ----------------------------------------------------------------------------
// ttslfp_hunt
// Header hunt, length capture and byte buffering; config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ttslfp_hunt (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr,
  input  wire logic [ttslfp_pkg::CFG_A_W-1:0] cfg_addr,
  input  wire logic [7:0]                     cfg_data,
  input  wire logic                           in_fire,
  input  wire logic [ttslfp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                                mem_we,
  output logic [ttslfp_pkg::ADDR_W-1:0]       mem_waddr,
  output logic [ttslfp_pkg::BYTE_W-1:0]       mem_wdata,
  output ttslfp_pkg::frame_done_t             done
);
  import ttslfp_pkg::*;

  localparam logic [COUNT_W-1:0] CNT_SYNC1 = COUNT_W'(0);
  localparam logic [COUNT_W-1:0] CNT_SYNC2 = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] CNT_TYPE  = COUNT_W'(2);
  localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(MAX_FRAME);

  logic [7:0]         sync1_r, sync2_r, code_a_r, code_b_r, ofs_a_r, ofs_b_r;
  logic [POS_W-1:0]   pos_a_r, pos_b_r;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic               typ_r, typ_nxt;
  logic [LEN_W-1:0]   exp_r, exp_nxt, exp_eff, len_cap;
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic               hit;
  logic [8:0]         len_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r  <= 8'd170;
      sync2_r  <= 8'd85;
      code_a_r <= 8'd1;
      code_b_r <= 8'd2;
      pos_a_r  <= POS_W'(3);
      pos_b_r  <= POS_W'(3);
      ofs_a_r  <= 8'd0;
      ofs_b_r  <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_SYNC_FIRST:  sync1_r  <= cfg_data;
        REG_SYNC_SECOND: sync2_r  <= cfg_data;
        REG_TYPE_A_CODE: code_a_r <= cfg_data;
        REG_TYPE_B_CODE: code_b_r <= cfg_data;
        REG_TYPE_A_POS:  pos_a_r  <= cfg_data[POS_W-1:0];
        REG_TYPE_B_POS:  pos_b_r  <= cfg_data[POS_W-1:0];
        REG_TYPE_A_OFS:  ofs_a_r  <= cfg_data;
        REG_TYPE_B_OFS:  ofs_b_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (!typ_r) begin
      hit     = (7'(cnt_r) == 7'(pos_a_r));
      len_sum = 9'(rx_byte) + 9'(ofs_a_r);
    end else begin
      hit     = (7'(cnt_r) == 7'(pos_b_r));
      len_sum = 9'(rx_byte) + 9'(ofs_b_r);
    end
    len_cap = (len_sum > 9'(MAX_FRAME)) ? LEN_MAX : len_sum[LEN_W-1:0];
    exp_eff = hit ? len_cap : exp_r;
    cnt_inc = cnt_r + COUNT_W'(1);
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    typ_nxt     = typ_r;
    exp_nxt     = exp_r;
    slot_nxt    = slot_r;
    mem_we      = 1'b0;
    mem_waddr   = cnt_r[ADDR_W-1:0];
    mem_wdata   = rx_byte;
    done.start  = 1'b0;
    done.n      = cnt_inc;
    done.type_b = typ_r;
    done.slot   = slot_r;
    if (in_fire) begin
      unique case (cnt_r)
        CNT_SYNC1: begin
          if (rx_byte == sync1_r) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_inc;
            exp_nxt = LEN_MAX;
          end
        end
        CNT_SYNC2: begin
          if (rx_byte == sync2_r) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_inc;
          end else begin
            cnt_nxt = CNT_SYNC1;
          end
        end
        CNT_TYPE: begin
          if (rx_byte == code_a_r) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_inc;
            typ_nxt = 1'b0;
          end else if (rx_byte == code_b_r) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_inc;
            typ_nxt = 1'b1;
          end else begin
            cnt_nxt = CNT_SYNC1;
          end
        end
        default: begin
          mem_we  = 1'b1;
          cnt_nxt = cnt_inc;
          exp_nxt = exp_eff;
          if ((7'(cnt_inc) >= exp_eff) || (cnt_inc >= COUNT_W'(MAX_FRAME))) begin
            done.start = 1'b1;
            cnt_nxt    = CNT_SYNC1;
            slot_nxt   = (slot_r == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      typ_r  <= 1'b0;
      exp_r  <= LEN_MAX;
      slot_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      typ_r  <= typ_nxt;
      exp_r  <= exp_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ttslfp_readout.sv */
// ----------------------------------------------------------------------------
// ttslfp_readout
// Frame readout: issue buffer reads and hold each word in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttslfp_readout (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ttslfp_pkg::frame_done_t       done,
  output logic                               busy,
  output logic                               mem_re,
  output logic [ttslfp_pkg::ADDR_W-1:0]      mem_raddr,
  input  wire logic [ttslfp_pkg::BYTE_W-1:0] mem_rdata,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ttslfp_pkg::BYTE_W-1:0]      out_byte,
  output logic [ttslfp_pkg::POS_W-1:0]       out_pos,
  output logic [ttslfp_pkg::LEN_W-1:0]       out_len,
  output logic                               out_type_b,
  output logic [2:0]                         out_slot,
  output logic                               out_last
);
  import ttslfp_pkg::*;

  logic               busy_r, busy_nxt;
  logic               pend_r;
  logic               oval_r, oval_nxt;
  logic [COUNT_W-1:0] n_r, k_r, k_nxt, rk_r;
  logic               type_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               issue, out_fire;

  assign out_fire  = oval_r && out_ready;
  assign issue     = busy_r && !pend_r && (!oval_r || out_fire);
  assign mem_re    = issue;
  assign mem_raddr = k_r[ADDR_W-1:0];
  assign busy      = busy_r;
  assign out_valid = oval_r;

  always_comb begin
    busy_nxt = busy_r;
    k_nxt    = k_r;
    if (done.start) begin
      busy_nxt = 1'b1;
      k_nxt    = '0;
    end else if (issue) begin
      k_nxt = k_r + COUNT_W'(1);
      if (k_nxt == n_r) begin
        busy_nxt = 1'b0;
      end
    end
    oval_nxt = pend_r ? 1'b1 : (out_fire ? 1'b0 : oval_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      oval_r <= 1'b0;
      k_r    <= '0;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= issue;
      oval_r <= oval_nxt;
      k_r    <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done.start) begin
      n_r    <= done.n;
      type_r <= done.type_b;
      slot_r <= done.slot;
    end
    if (issue) begin
      rk_r <= k_r;
    end
    if (pend_r) begin
      out_byte   <= mem_rdata;
      out_pos    <= POS_W'(rk_r);
      out_len    <= LEN_W'(n_r);
      out_type_b <= type_r;
      out_slot   <= 3'(slot_r);
      out_last   <= ((rk_r + COUNT_W'(1)) == n_r);
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done.start |-> !busy_r)
    else $error("frame completed while readout busy");
  a_pend_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !oval_r)
    else $error("read data arrived with output register full");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (k_r < n_r))
    else $error("read index past frame length");
  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (oval_r && !out_ready) |=> oval_r)
    else $error("output word dropped while stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/two_type_sync_length_frame_parser_unit.sv */
// ----------------------------------------------------------------------------
// two_type_sync_length_frame_parser_unit
// Sync/type header hunt with length-field framing and buffered frame readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per word (in_tdata[7:0]).
//   cfg_* : register writes, index on cfg_addr, value on cfg_data; always ready.
//           Write only while no frame is being read out.
//   out_* : one word per frame byte, in received order, tlast on the final
//           byte; tuser carries the type B flag.
// Accepted bytes that pass the header hunt, and all frame body bytes, are written
// to the frame buffer. When a frame completes, in_tready drops and the buffer is
// read back word by word: each read goes through the registered read port into
// the output register, and the next read is issued only when that register is
// free or being emptied. in_tready returns once the last read is issued, so the
// next frame may be received while the final word waits in the output register.
// A stalled receiver holds the output register and pauses the buffer reads.
// Reset (synchronous, rst_n low) restores register defaults, restarts the
// hunt and empties the output; buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module two_type_sync_length_frame_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] frame_byte, [13:8] byte_position,
                                       // [20:14] frame_length, [23:21] slot_index
  output logic             out_tuser,  // [0] frame_type_b
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [7:0]  cfg_data
);
  import ttslfp_pkg::*;

  frame_done_t         done;
  logic                busy, in_fire;
  logic                mem_we, mem_re;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic [BYTE_W-1:0]   mem_wdata, mem_rdata;
  logic [BYTE_W-1:0]   o_byte;
  logic [POS_W-1:0]    o_pos;
  logic [LEN_W-1:0]    o_len;
  logic [2:0]          o_slot;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;
  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {o_slot, o_len, o_pos, o_byte};

  ttslfp_hunt u_hunt (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .rx_byte   (in_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .done      (done)
  );

  ttslfp_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (MAX_FRAME)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ttslfp_readout u_readout (
    .clk        (clk),
    .rst_n      (rst_n),
    .done       (done),
    .busy       (busy),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (o_byte),
    .out_pos    (o_pos),
    .out_len    (o_len),
    .out_type_b (out_tuser),
    .out_slot   (o_slot),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire
